/* hw/rtl/npm_pkg.sv */
// Shared constants, codes and types of the negacyclic polynomial multiplier.
package npm_pkg;

	localparam int COEFF_COUNT = 1024;
	localparam int IDX_W       = 10;
	localparam int VAL_W       = 64;
	localparam int HALF_W      = VAL_W / 2;
	localparam int AW          = $clog2(COEFF_COUNT);

	typedef enum logic [1:0] {
		CMD_WRITE_FIRST  = 2'd0,
		CMD_WRITE_SECOND = 2'd1,
		CMD_MULTIPLY     = 2'd2,
		CMD_READ         = 2'd3
	} cmd_t;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_READ,
		ST_RESULT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;    // request taken this cycle
		logic start_mul; // clear the term counters
		logic issue;     // issue one multiply-accumulate term
		logic load_out;  // load the result register
		logic out_kind;  // kind of the result being loaded
	} npm_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic issue_last; // the final term is being issued
		logic pipe_empty; // no term in flight
	} npm_stat_t;

endpackage

/* hw/rtl/npm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module npm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/npm_datapath.sv */
// Datapath: operand and product stores, term addressing, pipelined MAC, result register.
module npm_datapath
	import npm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  npm_cmd_t         cmd,
	input  logic [1:0]       command,
	input  logic [IDX_W-1:0] coeff_index,
	input  logic [VAL_W-1:0] coeff_value,
	output npm_stat_t        stat,
	output logic             result_kind,
	output logic [IDX_W-1:0] result_index,
	output logic [VAL_W-1:0] result_value
);

	logic             in_range;
	logic             wr_a, wr_b;
	logic [AW-1:0]    wr_addr;
	logic [IDX_W-1:0] idx_q;
	logic             range_q;

	logic [AW-1:0] k_q, t_q;
	logic [AW:0]   diff;
	logic [AW-1:0] b_addr;
	logic          t_last;

	logic [VAL_W-1:0] a_rd, b_rd, p_rd;

	logic             v_s1, neg_s1, first_s1, last_s1;
	logic [AW-1:0]    k_s1;
	logic             v_s2, neg_s2, first_s2, last_s2;
	logic [AW-1:0]    k_s2;
	logic [VAL_W-1:0] lo_s2;
	logic [HALF_W-1:0] c1_s2, c2_s2;
	logic             v_s3, neg_s3, first_s3, last_s3;
	logic [AW-1:0]    k_s3;
	logic [VAL_W-1:0] p_s3;
	logic [VAL_W-1:0] acc_q, acc_base, acc_nxt;

	assign in_range = 32'(coeff_index) < 32'(COEFF_COUNT);
	assign wr_addr  = AW'(coeff_index);
	assign wr_a = cmd.accept && (cmd_t'(command) == CMD_WRITE_FIRST) && in_range;
	assign wr_b = cmd.accept && (cmd_t'(command) == CMD_WRITE_SECOND) && in_range;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			idx_q   <= coeff_index;
			range_q <= in_range;
		end
	end

	// term addressing: b index is (k - t) mod N, negated when t > k
	assign t_last = t_q == AW'(COEFF_COUNT - 1);
	assign diff   = {1'b0, k_q} - {1'b0, t_q};
	assign b_addr = (t_q > k_q) ? AW'(diff + (AW+1)'(COEFF_COUNT)) : AW'(diff);
	assign stat.issue_last = t_last && (k_q == AW'(COEFF_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q  <= '0;
			t_q  <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (cmd.start_mul) begin
				k_q <= '0;
				t_q <= '0;
			end else if (cmd.issue) begin
				if (t_last) begin
					t_q <= '0;
					k_q <= k_q + 1'b1;
				end else begin
					t_q <= t_q + 1'b1;
				end
			end
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign stat.pipe_empty = !v_s1 && !v_s2 && !v_s3;

	npm_ram #(.WIDTH(VAL_W), .DEPTH(COEFF_COUNT)) u_ram_a (
		.clk(clk), .we(wr_a), .waddr(wr_addr), .wdata(coeff_value),
		.raddr(t_q), .rdata(a_rd)
	);

	npm_ram #(.WIDTH(VAL_W), .DEPTH(COEFF_COUNT)) u_ram_b (
		.clk(clk), .we(wr_b), .waddr(wr_addr), .wdata(coeff_value),
		.raddr(b_addr), .rdata(b_rd)
	);

	// stage 1 flags ride alongside the RAM read
	always_ff @(posedge clk) begin
		neg_s1   <= t_q > k_q;
		first_s1 <= t_q == '0;
		last_s1  <= t_last;
		k_s1     <= k_q;
	end

	// stage 2: three 32x32 partial products (low 64 bits of a*b)
	always_ff @(posedge clk) begin
		lo_s2    <= VAL_W'(a_rd[HALF_W-1:0]) * VAL_W'(b_rd[HALF_W-1:0]);
		c1_s2    <= a_rd[HALF_W-1:0] * b_rd[VAL_W-1:HALF_W];
		c2_s2    <= a_rd[VAL_W-1:HALF_W] * b_rd[HALF_W-1:0];
		neg_s2   <= neg_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		k_s2     <= k_s1;
	end

	// stage 3: combine partials
	always_ff @(posedge clk) begin
		p_s3     <= lo_s2 + {c1_s2 + c2_s2, {HALF_W{1'b0}}};
		neg_s3   <= neg_s2;
		first_s3 <= first_s2;
		last_s3  <= last_s2;
		k_s3     <= k_s2;
	end

	assign acc_base = first_s3 ? '0 : acc_q;
	assign acc_nxt  = neg_s3 ? acc_base - p_s3 : acc_base + p_s3;

	always_ff @(posedge clk) begin
		if (v_s3) begin
			acc_q <= acc_nxt;
		end
	end

	npm_ram #(.WIDTH(VAL_W), .DEPTH(COEFF_COUNT)) u_ram_p (
		.clk(clk), .we(v_s3 && last_s3), .waddr(k_s3), .wdata(acc_nxt),
		.raddr(AW'(idx_q)), .rdata(p_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_kind <= cmd.out_kind;
			if (cmd.out_kind == KIND_DONE) begin
				result_index <= '0;
				result_value <= '0;
			end else begin
				result_index <= idx_q;
				result_value <= range_q ? p_rd : '0;
			end
		end
	end

endmodule

/* hw/rtl/npm_ctrl.sv */
// Controller: request sequencing and result handshake.
module npm_ctrl
	import npm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] command,
	output logic       out_valid,
	input  logic       out_ready,
	input  npm_stat_t  stat,
	output npm_cmd_t   cmd
);

	state_t state_q, state_nxt;
	logic   kind_q, kind_nxt;
	logic   slot_free;

	assign slot_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			kind_q    <= KIND_READ;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_nxt;
			kind_q  <= kind_nxt;
			if (cmd.load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt     = state_q;
		kind_nxt      = kind_q;
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.out_kind  = kind_q;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					case (cmd_t'(command))
						CMD_MULTIPLY: begin
							cmd.start_mul = 1'b1;
							kind_nxt      = KIND_DONE;
							state_nxt     = ST_MAC;
						end
						CMD_READ: begin
							kind_nxt  = KIND_READ;
							state_nxt = ST_READ;
						end
						default: ;
					endcase
				end
			end
			ST_MAC: begin
				cmd.issue = 1'b1;
				if (stat.issue_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (stat.pipe_empty) begin
					state_nxt = ST_RESULT;
				end
			end
			ST_READ: begin
				state_nxt = ST_RESULT;
			end
			ST_RESULT: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/negacyclic_poly_multiply.sv */
// Top level of the negacyclic polynomial multiplier.
//
// Multiplies two polynomials of COEFF_COUNT 64-bit coefficients modulo x^N + 1, all
// arithmetic wrapping modulo 2^64. A request either writes one coefficient of the first
// or second operand (no result; out-of-range index ignored), runs the multiply (one
// completion result, kind 1), or reads one product coefficient (kind 0; zero value for
// an out-of-range index). One request is handled at a time. A write leaves the block idle.
// A read holds the block while it reads the product RAM and then loads the result
// register, which waits until the output register is free. The multiply walks all
// N*N terms through a single pipelined multiply-accumulate unit, one term per cycle,
// holding the block while it issues every term, drains the three-stage MAC pipeline,
// loads the result and returns to idle. That single MAC and its operand RAM read
// ports set the pace. The 64-bit product is built from three 32x32 partial products.
// Operand entries must be written before a multiply reads them and the product store
// holds nothing meaningful before the first multiply. Results sit in an output
// register; a new request can be taken while one waits, but the next result is held
// back until it is taken.
module negacyclic_poly_multiply
	import npm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       command,
	input  logic [IDX_W-1:0] coeff_index,
	input  logic [VAL_W-1:0] coeff_value,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             result_kind,
	output logic [IDX_W-1:0] result_index,
	output logic [VAL_W-1:0] result_value
);

	npm_cmd_t  cmd;
	npm_stat_t stat;

	npm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	npm_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.command      (command),
		.coeff_index  (coeff_index),
		.coeff_value  (coeff_value),
		.stat         (stat),
		.result_kind  (result_kind),
		.result_index (result_index),
		.result_value (result_value)
	);

endmodule
